>>> design/mes_pkg.sv
// ----------------------------------------------------------------------------
// Motor enable sequencer package
// Shared widths, command codes and the types passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mes_pkg;

   // Field widths
   localparam int MASK_WIDTH          = 12;
   localparam int MODE_WIDTH          = 8;
   localparam int MOTOR_NUM_WIDTH     = 4;
   localparam int VALUE_WIDTH         = 4;
   localparam int MOTOR_COUNT_DEFAULT = 12;

   // Control modes
   localparam logic [MODE_WIDTH-1:0] MODE_IMPEDANCE = 8'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_POSITION  = 8'd1;

   // Parameter values
   localparam logic [VALUE_WIDTH-1:0] VAL_NONE          = 4'd0;
   localparam logic [VALUE_WIDTH-1:0] VAL_RUN_IMPEDANCE = 4'd0;
   localparam logic [VALUE_WIDTH-1:0] VAL_RUN_POSITION  = 4'd5;
   localparam logic [VALUE_WIDTH-1:0] VAL_SPEED_LIMIT   = 4'd15;

   typedef enum logic [1:0] {
      KIND_ENABLE     = 2'd0,
      KIND_STOP       = 2'd1,
      KIND_STOP_CLEAR = 2'd2,
      KIND_PARAM      = 2'd3
   } cmd_kind_type;

   typedef enum logic {
      SEL_RUN_MODE    = 1'b0,
      SEL_SPEED_LIMIT = 1'b1
   } param_sel_type;

   // Position within one motor's command sequence
   typedef enum logic [1:0] {
      STEP_CLEAR  = 2'd0,
      STEP_MODE   = 2'd1,
      STEP_ENABLE = 2'd2,
      STEP_LIMIT  = 2'd3
   } step_type;

   // Sequencer view of the current motor, into the step unit
   typedef struct packed {
      logic                       turn_on;
      logic                       turn_off;
      logic                       clear;
      logic                       higher_change;
      logic [MODE_WIDTH-1:0]      mode;
      step_type                   step;
      logic [MOTOR_NUM_WIDTH-1:0] motor;
   } step_in_type;

   // Command produced by the step unit
   typedef struct packed {
      logic                       emit;
      logic                       motor_done;
      logic                       last;
      logic [MOTOR_NUM_WIDTH-1:0] motor;
      cmd_kind_type               kind;
      param_sel_type              sel;
      logic [VALUE_WIDTH-1:0]     value;
   } cmd_type;

endpackage

`default_nettype wire

>>> design/mes_step_unit.sv
// ----------------------------------------------------------------------------
// Motor enable sequencer step unit
// Decodes one sequence step of one motor into a command and the next move.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_step_unit
   import mes_pkg::*;
(
   input  step_in_type step_in,
   output cmd_type     cmd_out
);

   logic mode_imp;
   logic mode_pos;

   assign mode_imp = (step_in.mode == MODE_IMPEDANCE);
   assign mode_pos = (step_in.mode == MODE_POSITION);

   // Build the command for this step
   always_comb begin
      cmd_out            = '0;
      cmd_out.motor      = step_in.motor;
      cmd_out.kind       = KIND_ENABLE;
      cmd_out.sel        = SEL_RUN_MODE;
      cmd_out.value      = VAL_NONE;
      case (step_in.step)
         STEP_CLEAR: begin
            if (step_in.turn_on) begin
               cmd_out.emit = step_in.clear;
               cmd_out.kind = KIND_STOP_CLEAR;
            end else if (step_in.turn_off) begin
               cmd_out.emit       = 1'b1;
               cmd_out.kind       = KIND_STOP;
               cmd_out.motor_done = 1'b1;
            end else begin
               cmd_out.motor_done = 1'b1;
            end
         end
         STEP_MODE: begin
            cmd_out.emit  = mode_imp || mode_pos;
            cmd_out.kind  = KIND_PARAM;
            cmd_out.sel   = SEL_RUN_MODE;
            cmd_out.value = mode_pos ? VAL_RUN_POSITION : VAL_RUN_IMPEDANCE;
         end
         STEP_ENABLE: begin
            cmd_out.emit       = 1'b1;
            cmd_out.kind       = KIND_ENABLE;
            cmd_out.motor_done = !mode_pos;
         end
         STEP_LIMIT: begin
            cmd_out.emit       = mode_pos;
            cmd_out.kind       = KIND_PARAM;
            cmd_out.sel        = SEL_SPEED_LIMIT;
            cmd_out.value      = VAL_SPEED_LIMIT;
            cmd_out.motor_done = 1'b1;
         end
         default: begin
            cmd_out.motor_done = 1'b1;
         end
      endcase
      // Final command of the message: last of this motor, nothing above
      cmd_out.last = cmd_out.emit && cmd_out.motor_done && !step_in.higher_change;
   end

endmodule

`default_nettype wire

>>> design/motor_enable_sequencer_core.sv
// The first command of a message is loaded into the output register once
// the scan reaches it and the output is free; the scan starts the cycle
// after the request is accepted. Throughput: one step per cycle while the
// output is not stalled, over min(MOTOR_COUNT,12) motors; an unchanged or
// stopped motor takes one step, an enabled motor three or four; req_tready
// is low while the scan runs. Reset: synchronous, clears mask, mode, sequencer.
// ----------------------------------------------------------------------------
// Motor enable sequencer core
// Scans the motors in order and emits the enable and stop command runs.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_enable_sequencer_core
   import mes_pkg::*;
#(
   parameter int MOTOR_COUNT = MOTOR_COUNT_DEFAULT
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [11:0] want_enable_mask, [23:12] fault_clear_mask, [31:24] control_mode
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] motor_number, [7:4] parameter_value
   output logic [7:0]       rsp_tdata,
   // [1:0] command_kind, [2] parameter_select
   output logic [2:0]       rsp_tuser,
   // last_of_run
   output logic             rsp_tlast
);

   localparam int SCAN_COUNT = (MOTOR_COUNT < MASK_WIDTH) ? MOTOR_COUNT : MASK_WIDTH;
   localparam int IDX_W      = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   logic [MASK_WIDTH-1:0] req_want;
   logic [MASK_WIDTH-1:0] req_clear;
   logic [MODE_WIDTH-1:0] req_mode;

   state_type             state_ff,        state_in;
   logic [MASK_WIDTH-1:0] enabled_mask_ff, enabled_mask_in;
   logic [MODE_WIDTH-1:0] current_mode_ff, current_mode_in;
   logic [SCAN_COUNT-1:0] on_mask_ff,      on_mask_in;
   logic [SCAN_COUNT-1:0] off_mask_ff,     off_mask_in;
   logic [SCAN_COUNT-1:0] clear_mask_ff,   clear_mask_in;
   logic [IDX_W-1:0]      idx_ff,          idx_in;
   step_type              step_ff,         step_in;
   logic                  rsp_valid_ff,    rsp_valid_in;
   cmd_type               rsp_cmd_ff,      rsp_cmd_in;

   logic                  accept;
   logic                  out_free;
   logic                  advance;
   logic                  higher_change;
   step_in_type           unit_in;
   cmd_type               unit_cmd;

   assign req_want  = req_tdata[11:0];
   assign req_clear = req_tdata[23:12];
   assign req_mode  = req_tdata[31:24];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Look for any change at a motor above the current one
   always_comb begin
      higher_change = 1'b0;
      for (int j = 0; j < SCAN_COUNT; j++) begin
         if ((j > int'(idx_ff)) && (on_mask_ff[j] || off_mask_ff[j])) begin
            higher_change = 1'b1;
         end
      end
   end

   // Feed the shared step unit
   always_comb begin
      unit_in               = '0;
      unit_in.turn_on       = on_mask_ff[idx_ff];
      unit_in.turn_off      = off_mask_ff[idx_ff];
      unit_in.clear         = clear_mask_ff[idx_ff];
      unit_in.higher_change = higher_change;
      unit_in.mode          = current_mode_ff;
      unit_in.step          = step_ff;
      unit_in.motor         = MOTOR_NUM_WIDTH'(idx_ff) + MOTOR_NUM_WIDTH'(1);
   end

   mes_step_unit u_step_unit (
      .step_in (unit_in),
      .cmd_out (unit_cmd)
   );

   assign advance = (state_ff == ST_SCAN) && (!unit_cmd.emit || out_free);

   // Sequencer: accept a request, then walk motors and steps
   always_comb begin
      state_in        = state_ff;
      enabled_mask_in = enabled_mask_ff;
      current_mode_in = current_mode_ff;
      on_mask_in      = on_mask_ff;
      off_mask_in     = off_mask_ff;
      clear_mask_in   = clear_mask_ff;
      idx_in          = idx_ff;
      step_in         = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               on_mask_in      = req_want[SCAN_COUNT-1:0] & ~enabled_mask_ff[SCAN_COUNT-1:0];
               off_mask_in     = ~req_want[SCAN_COUNT-1:0] & enabled_mask_ff[SCAN_COUNT-1:0];
               clear_mask_in   = req_clear[SCAN_COUNT-1:0];
               enabled_mask_in = req_want;
               current_mode_in = req_mode;
               idx_in          = '0;
               step_in         = STEP_CLEAR;
               state_in        = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (unit_cmd.motor_done) begin
                  step_in = STEP_CLEAR;
                  if (idx_ff == IDX_W'(SCAN_COUNT - 1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end else begin
                  step_in = step_type'(step_ff + 2'd1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load a new command, drop a taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      if (advance && unit_cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_cmd_in   = unit_cmd;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         enabled_mask_ff <= '0;
         current_mode_ff <= MODE_IMPEDANCE;
         idx_ff          <= '0;
         step_ff         <= STEP_CLEAR;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         enabled_mask_ff <= enabled_mask_in;
         current_mode_ff <= current_mode_in;
         idx_ff          <= idx_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      on_mask_ff    <= on_mask_in;
      off_mask_ff   <= off_mask_in;
      clear_mask_ff <= clear_mask_in;
      rsp_cmd_ff    <= rsp_cmd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_cmd_ff.value, rsp_cmd_ff.motor};
   assign rsp_tuser  = {rsp_cmd_ff.sel, rsp_cmd_ff.kind};
   assign rsp_tlast  = rsp_cmd_ff.last;

endmodule

`default_nettype wire

>>> design/mes_checker.sv
// ----------------------------------------------------------------------------
// Motor enable sequencer checker
// Port-level checks on the command stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_checker
   import mes_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [2:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   // A stalled command holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled command changed");

   // No new request while a scan runs
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during scan");

   // Motor number in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] != 4'd0) && (rsp_tdata[3:0] <= 4'd12))
      else $error("motor number out of range");

   // Enable and stop carry no parameter
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] != KIND_PARAM)
         |-> (rsp_tdata[7:4] == VAL_NONE) && (rsp_tuser[2] == SEL_RUN_MODE))
      else $error("parameter fields set on non-write command");

   // Parameter write values match their selection
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == KIND_PARAM)
         |-> (rsp_tuser[2] == SEL_SPEED_LIMIT) ? (rsp_tdata[7:4] == VAL_SPEED_LIMIT)
            : ((rsp_tdata[7:4] == VAL_RUN_IMPEDANCE) || (rsp_tdata[7:4] == VAL_RUN_POSITION)))
      else $error("parameter value does not match selection");

endmodule

bind motor_enable_sequencer_core mes_checker u_mes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

>>> verif/motor_enable_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// Motor enable sequencer core testbench
// Sends supervisory requests, predicts each command run from a shadow copy of
// the enabled mask and checks every command field, under random idling and
// a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_enable_sequencer_core_tb
   import mes_pkg::*;
();

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 12;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int LIMIT_CYCLES = 250000;

   // One expected command on the result stream
   typedef struct {
      logic [MOTOR_NUM_WIDTH-1:0] motor;
      cmd_kind_type               kind;
      param_sel_type              sel;
      logic [VALUE_WIDTH-1:0]     value;
      logic                       last;
   } motor_cmd_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [11:0] want_enable_mask, [23:12] fault_clear_mask, [31:24] control_mode
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [3:0] motor_number, [7:4] parameter_value
   logic [7:0]  rsp_tdata;
   // [1:0] command_kind, [2] parameter_select
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // Shadow state of the block
   logic [MASK_WIDTH-1:0] model_enabled = '0;
   motor_cmd_type         pending_commands[$];

   int error_count   = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int hold_requests = 0;

   motor_enable_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic motor_cmd_type make_cmd(input logic [MOTOR_NUM_WIDTH-1:0] motor,
                                              input cmd_kind_type kind,
                                              input param_sel_type sel,
                                              input logic [VALUE_WIDTH-1:0] value);
      motor_cmd_type cmd;
      cmd.motor = motor;
      cmd.kind  = kind;
      cmd.sel   = sel;
      cmd.value = value;
      cmd.last  = 1'b0;
      return cmd;
   endfunction

   // Work out the command run of one request and queue it
   function automatic void predict_command_run(input logic [MASK_WIDTH-1:0] want,
                                               input logic [MASK_WIDTH-1:0] clear,
                                               input logic [MODE_WIDTH-1:0] mode);
      motor_cmd_type              run[$];
      logic [MOTOR_NUM_WIDTH-1:0] motor;
      for (int n = 0; n < MASK_WIDTH; n++) begin
         motor = MOTOR_NUM_WIDTH'(n + 1);
         if (want[n] && !model_enabled[n]) begin
            if (clear[n])
               run.push_back(make_cmd(motor, KIND_STOP_CLEAR, SEL_RUN_MODE, VAL_NONE));
            if (mode == MODE_IMPEDANCE)
               run.push_back(make_cmd(motor, KIND_PARAM, SEL_RUN_MODE, VAL_RUN_IMPEDANCE));
            else if (mode == MODE_POSITION)
               run.push_back(make_cmd(motor, KIND_PARAM, SEL_RUN_MODE, VAL_RUN_POSITION));
            run.push_back(make_cmd(motor, KIND_ENABLE, SEL_RUN_MODE, VAL_NONE));
            if (mode == MODE_POSITION)
               run.push_back(make_cmd(motor, KIND_PARAM, SEL_SPEED_LIMIT, VAL_SPEED_LIMIT));
         end else if (!want[n] && model_enabled[n]) begin
            run.push_back(make_cmd(motor, KIND_STOP, SEL_RUN_MODE, VAL_NONE));
         end
      end
      if (run.size() > 0)
         run[run.size()-1].last = 1'b1;
      foreach (run[i])
         pending_commands.push_back(run[i]);
      model_enabled = want;
   endfunction

   // Offer one request, with a random gap first, and predict it once accepted
   task automatic send_message(input logic [MASK_WIDTH-1:0] want,
                               input logic [MASK_WIDTH-1:0] clear,
                               input logic [MODE_WIDTH-1:0] mode);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mode, clear, want};
      do @(posedge clock); while (!req_tready);
      predict_command_run(want, clear, mode);
   endtask

   // Hold the sender until every expected command has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_commands.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_message(12'hFFF, 12'hFFF, MODE_IMPEDANCE);  // all on with clear
      send_message(12'h000, 12'h000, MODE_IMPEDANCE);  // all off
      send_message(12'hFFF, 12'hFFF, MODE_POSITION);   // longest run
      send_message(12'hFFF, 12'hFFF, 8'd7);            // no change, mode recorded
      send_message(12'h000, 12'hFFF, 8'hFF);           // clear bits on stopping motors
      send_message(12'hFFF, 12'h000, 8'hFF);           // unknown mode, enable only
      send_message(12'h000, 12'h000, 8'h80);
      send_message(12'h001, 12'h001, MODE_POSITION);   // motor 1 alone
      send_message(12'h800, 12'h800, MODE_IMPEDANCE);  // motor 12 on, motor 1 off
      send_message(12'h800, 12'hFFF, MODE_POSITION);   // clear without turn-on
      send_message(12'hAAA, 12'h555, MODE_POSITION);
      send_message(12'h555, 12'hAAA, MODE_IMPEDANCE);
      send_message(12'hAAA, 12'hAAA, 8'd2);
      send_message(12'h555, 12'h555, 8'hFE);
      send_message(12'h000, 12'h000, 8'h00);
      send_message(12'h000, 12'hFFF, MODE_POSITION);   // no change from all off
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count);
      logic [MASK_WIDTH-1:0] want;
      logic [MASK_WIDTH-1:0] clear;
      logic [MODE_WIDTH-1:0] mode;
      int                    pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 15)
            want = model_enabled;
         else if (pick < 60)
            want = model_enabled ^ (MASK_WIDTH'(1) << $urandom_range(MASK_WIDTH-1))
                                 ^ (MASK_WIDTH'($urandom_range(1)) << $urandom_range(MASK_WIDTH-1));
         else
            want = MASK_WIDTH'($urandom_range(4095));
         clear = ($urandom_range(9) == 0) ? 12'hFFF : MASK_WIDTH'($urandom_range(4095));
         pick  = $urandom_range(99);
         if (pick < 40)
            mode = MODE_IMPEDANCE;
         else if (pick < 80)
            mode = MODE_POSITION;
         else
            mode = MODE_WIDTH'($urandom_range(255));
         send_message(want, clear, mode);
      end
      wait_drained();
   endtask

   // Stall the result side for a long stretch while requests keep coming
   task automatic test_output_stall();
      hold_requests++;
      send_message(12'hFFF, 12'h0F0, MODE_POSITION);
      send_message(12'h000, 12'h000, MODE_IMPEDANCE);
      send_message(12'h3C3, 12'hFFF, MODE_IMPEDANCE);
      send_message(12'hC3C, 12'h00F, MODE_POSITION);
      send_message(12'hFFF, 12'hFFF, 8'd9);
      send_message(12'h000, 12'h000, MODE_POSITION);
      send_message(12'hFFF, 12'hFFF, MODE_POSITION);
      send_message(12'h000, 12'h000, MODE_IMPEDANCE);
      wait_drained();
   endtask

   // Receiver: random stalls, plus a long hold-off when one is requested
   int hold_taken = 0;
   int hold_left  = 0;
   always @(posedge clock) begin
      if (hold_requests != hold_taken) begin
         hold_taken = hold_requests;
         hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Compare each accepted command with the oldest expectation
   always @(posedge clock) begin
      motor_cmd_type exp_cmd;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_commands.size() == 0) begin
            $error("unexpected command: motor %0d kind %0d", rsp_tdata[3:0], rsp_tuser[1:0]);
            error_count++;
         end else begin
            exp_cmd = pending_commands.pop_front();
            if (rsp_tdata[3:0] !== exp_cmd.motor) begin
               $error("motor_number: expected %0d, got %0d", exp_cmd.motor, rsp_tdata[3:0]);
               error_count++;
            end
            if (rsp_tuser[1:0] !== exp_cmd.kind) begin
               $error("command_kind: expected %0d, got %0d", exp_cmd.kind, rsp_tuser[1:0]);
               error_count++;
            end
            if (rsp_tuser[2] !== exp_cmd.sel) begin
               $error("parameter_select: expected %0d, got %0d", exp_cmd.sel, rsp_tuser[2]);
               error_count++;
            end
            if (rsp_tdata[7:4] !== exp_cmd.value) begin
               $error("parameter_value: expected %0d, got %0d", exp_cmd.value, rsp_tdata[7:4]);
               error_count++;
            end
            if (rsp_tlast !== exp_cmd.last) begin
               $error("last_of_run: expected %0d, got %0d", exp_cmd.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      req_idle_pct = 30;
      rsp_idle_pct = 57;
      test_random_traffic(36);
      req_idle_pct = 57;
      rsp_idle_pct = 30;
      test_random_traffic(36);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(34);
      test_output_stall();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_commands.size() != 0) begin
         $error("%0d commands never arrived", pending_commands.size());
         error_count++;
      end
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
